// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and active-low reset.
`define CHK_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) \
        else $error("assertion failed");

// Same-cycle implication under clock and active-low reset.
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ===== src/ptka_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the peer table with keepalive aging.
// No dependencies; imported by the cell, sequencer and top-level modules.
package ptka_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int ID_W     = 48;
    localparam int FLAG_W   = 8;
    localparam int TIME_W   = 48;
    localparam int KA_W     = 16;
    localparam int MASK_W   = 8;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 3;
    localparam int MS_W     = 10;
    localparam int SPAN_W   = KA_W + MS_W;

    localparam logic [MS_W-1:0]  MS_TO_US     = MS_W'(1000);
    localparam logic [KA_W-1:0]  KEEPALIVE_RST = KA_W'(20000);
    localparam logic [MASK_W-1:0] BUTTON_RST  = MASK_W'(1);
    localparam logic [MASK_W-1:0] RINGER_RST  = MASK_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    localparam logic KIND_HEARTBEAT = 1'b0;
    localparam logic KIND_SWEEP     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHANGED   = 3'd4;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_KEEPALIVE = 2'd0;
    localparam logic [1:0] REG_BUTTON    = 2'd1;
    localparam logic [1:0] REG_RINGER    = 2'd2;

    // Item fields broadcast to every cell while it is in flight.
    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [FLAG_W-1:0] flags;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] oldest;
        logic [MASK_W-1:0] button_mask;
        logic [MASK_W-1:0] ringer_mask;
    } ptka_item_t;

    // Token handed from cell to cell.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] live;
        logic [CNT_W-1:0] btn;
        logic [CNT_W-1:0] rng;
    } ptka_tok_t;

    // Entry write command after a heartbeat scan.
    typedef struct packed {
        logic             en;
        logic             load_id;
        logic [IDX_W-1:0] idx;
    } ptka_wr_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/ptka_cell.sv =====
`timescale 1ns / 1ps
// One table entry plus its stage of the scan token chain.
// Depends on ptka_pkg.
module ptka_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ptka_pkg::IDX_W-1:0] cell_idx,
    input  ptka_pkg::ptka_item_t       item,
    input  ptka_pkg::ptka_wr_t         wr,
    input  ptka_pkg::ptka_tok_t        tok_in,
    output ptka_pkg::ptka_tok_t        tok_out
);
    import ptka_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic [ID_W-1:0]   id_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [TIME_W-1:0] seen_reg;
    ptka_tok_t         tok_reg;
    ptka_tok_t         tok_next;
    logic              wr_hit;

    assign wr_hit  = wr.en && (wr.idx == cell_idx);
    assign tok_out = tok_reg;

    always_comb
    begin
        tok_next    = tok_in;
        active_next = active_reg;
        if (tok_in.vld)
        begin
            if (item.kind == KIND_HEARTBEAT)
            begin
                if (!tok_in.hit)
                begin
                    if (id_reg == item.id)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = cell_idx;
                    end
                    else if (!active_reg)
                    begin
                        tok_next.free     = 1'b1;
                        tok_next.free_idx = cell_idx;
                    end
                end
            end
            else if (active_reg)
            begin
                if (seen_reg < item.oldest)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    tok_next.live = sat_inc(tok_in.live);
                    if ((flags_reg & item.button_mask) != '0)
                    begin
                        tok_next.btn = sat_inc(tok_in.btn);
                    end
                    if ((flags_reg & item.ringer_mask) != '0)
                    begin
                        tok_next.rng = sat_inc(tok_in.rng);
                    end
                end
            end
        end
        if (wr_hit)
        begin
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            id_reg     <= '0;
            flags_reg  <= '0;
            seen_reg   <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
            if (wr_hit)
            begin
                flags_reg <= item.flags;
                seen_reg  <= item.now;
                if (wr.load_id)
                begin
                    id_reg <= item.id;
                end
            end
        end
    end

endmodule

// ===== src/ptka_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: takes one transaction, launches the scan token, commits the
// result and drives the output register. Depends on ptka_pkg.
module ptka_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [ptka_pkg::ID_W-1:0]     in_id,
    input  logic [ptka_pkg::FLAG_W-1:0]   in_flags,
    input  logic [ptka_pkg::TIME_W-1:0]   in_now,
    input  logic [ptka_pkg::KA_W-1:0]     keepalive_ms,
    input  logic [ptka_pkg::MASK_W-1:0]   button_mask,
    input  logic [ptka_pkg::MASK_W-1:0]   ringer_mask,
    output ptka_pkg::ptka_item_t          item,
    output ptka_pkg::ptka_tok_t           tok_launch,
    input  ptka_pkg::ptka_tok_t           tok_end,
    output ptka_pkg::ptka_wr_t            wr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptka_pkg::STATUS_W-1:0] out_status,
    output logic [ptka_pkg::CNT_W-1:0]    out_live,
    output logic [ptka_pkg::CNT_W-1:0]    out_button,
    output logic [ptka_pkg::CNT_W-1:0]    out_ringer,
    output logic [ptka_pkg::CNT_W-1:0]    out_peak
);
    import ptka_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_WRITE
    } state_t;

    state_t              state_reg;
    ptka_item_t          item_reg;
    ptka_tok_t           tok_reg;
    ptka_wr_t            wr_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    live_reg;
    logic [CNT_W-1:0]    btn_reg;
    logic [CNT_W-1:0]    rng_reg;
    logic [CNT_W-1:0]    peak_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]    out_live_reg;
    logic [CNT_W-1:0]    out_button_reg;
    logic [CNT_W-1:0]    out_ringer_reg;
    logic [CNT_W-1:0]    out_peak_reg;
    logic [TIME_W-1:0]   span_ext;
    logic                changed;
    ptka_tok_t           tok_first;

    assign in_ready   = (state_reg == S_IDLE);
    assign item       = item_reg;
    assign tok_launch = tok_reg;
    assign wr         = wr_reg;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_live   = out_live_reg;
    assign out_button = out_button_reg;
    assign out_ringer = out_ringer_reg;
    assign out_peak   = out_peak_reg;

    assign span_ext = TIME_W'(span_reg);
    assign changed  = (tok_end.live != live_reg) || (tok_end.btn != btn_reg) ||
                      (tok_end.rng != rng_reg) || (peak_reg < tok_end.live);

    always_comb
    begin
        tok_first     = '0;
        tok_first.vld = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            tok_reg        <= '0;
            wr_reg         <= '0;
            span_reg       <= SPAN_W'(KEEPALIVE_RST) * SPAN_W'(MS_TO_US);
            status_reg     <= ST_UPDATED;
            live_reg       <= '0;
            btn_reg        <= '0;
            rng_reg        <= '0;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_UPDATED;
            out_live_reg   <= '0;
            out_button_reg <= '0;
            out_ringer_reg <= '0;
            out_peak_reg   <= '0;
        end
        else
        begin
            span_reg             <= SPAN_W'(keepalive_ms) * SPAN_W'(MS_TO_US);
            item_reg.button_mask <= button_mask;
            item_reg.ringer_mask <= ringer_mask;
            tok_reg              <= (state_reg == S_PREP) ? tok_first : '0;
            wr_reg.en            <= (state_reg == S_SCAN) && tok_end.vld &&
                                    (item_reg.kind == KIND_HEARTBEAT) &&
                                    (tok_end.hit || tok_end.free);
            if (out_valid_reg && out_ready && (state_reg != S_WRITE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg.kind  <= in_kind;
                        item_reg.id    <= in_id;
                        item_reg.flags <= in_flags;
                        item_reg.now   <= in_now;
                        state_reg      <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    item_reg.oldest <= (item_reg.now > span_ext) ?
                                       item_reg.now - span_ext : '0;
                    state_reg       <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (tok_end.vld)
                    begin
                        if (item_reg.kind == KIND_SWEEP)
                        begin
                            status_reg <= changed ? ST_CHANGED : ST_UNCHANGED;
                            live_reg   <= tok_end.live;
                            btn_reg    <= tok_end.btn;
                            rng_reg    <= tok_end.rng;
                            if (peak_reg < tok_end.live)
                            begin
                                peak_reg <= tok_end.live;
                            end
                        end
                        else if (tok_end.hit)
                        begin
                            status_reg     <= ST_UPDATED;
                            wr_reg.load_id <= 1'b0;
                            wr_reg.idx     <= tok_end.hit_idx;
                        end
                        else if (tok_end.free)
                        begin
                            status_reg     <= ST_INSERTED;
                            wr_reg.load_id <= 1'b1;
                            wr_reg.idx     <= tok_end.free_idx;
                        end
                        else
                        begin
                            status_reg <= ST_FULL;
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_live_reg   <= live_reg;
                        out_button_reg <= btn_reg;
                        out_ringer_reg <= rng_reg;
                        out_peak_reg   <= peak_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/peer_table_keepalive_aging.sv =====
`timescale 1ns / 1ps
// Top level of the peer table with keepalive aging: register port, stream
// channels, sequencer and cell chain. Depends on ptka_pkg, ptka_ctrl, ptka_cell.
//
// Usage:
//   Input stream (s_*): one transaction per heartbeat (s_tuser = 0) or sweep
//   (s_tuser = 1). tdata carries node id, flags and time.
//   Output stream (m_*): one transaction per input, with status and counts.
//   Registers (APB): keepalive_ms at 0x0, button_mask at 0x4, ringer_mask at
//   0x8; write only while no transaction is in flight.
//   Flow: the sequencer launches the scan token, which walks the chain of 16
//   entry cells, one cell per cycle, then registers the result; no new
//   transaction is taken until the result is in the output register.
//   Reset: table cleared (all ids zero, all inactive), counts zero,
//   registers to 20000 / 1 / 2; s_tready is high from reset on.
//   Stall: the result sits in the output register until m_tready; the
//   sequencer holds the next result until the register frees up and takes
//   no new input until then.
module peer_table_keepalive_aging (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptka_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [103:0]                 s_tdata,  // node_id, cap_flags, time_now
    input  logic                         s_tuser,  // kind
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata   // status, live, button, ringer, peak
);
    import ptka_pkg::*;

    logic [KA_W-1:0]     keepalive_reg;
    logic [MASK_W-1:0]   button_reg;
    logic [MASK_W-1:0]   ringer_reg;
    logic                cfg_wr;
    logic [1:0]          reg_idx;
    ptka_item_t          item;
    ptka_wr_t            wr;
    ptka_tok_t           tok [TABLE_DEPTH+1];
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    live;
    logic [CNT_W-1:0]    button;
    logic [CNT_W-1:0]    ringer;
    logic [CNT_W-1:0]    peak;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keepalive_reg <= KEEPALIVE_RST;
            button_reg    <= BUTTON_RST;
            ringer_reg    <= RINGER_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_KEEPALIVE: keepalive_reg <= pwdata[KA_W-1:0];
                REG_BUTTON:    button_reg    <= pwdata[MASK_W-1:0];
                REG_RINGER:    ringer_reg    <= pwdata[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEEPALIVE: prdata = 32'(keepalive_reg);
            REG_BUTTON:    prdata = 32'(button_reg);
            REG_RINGER:    prdata = 32'(ringer_reg);
            default:       prdata = '0;
        endcase
    end

    ptka_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_id        (s_tdata[47:0]),
        .in_flags     (s_tdata[55:48]),
        .in_now       (s_tdata[103:56]),
        .keepalive_ms (keepalive_reg),
        .button_mask  (button_reg),
        .ringer_mask  (ringer_reg),
        .item         (item),
        .tok_launch   (tok[0]),
        .tok_end      (tok[TABLE_DEPTH]),
        .wr           (wr),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (status),
        .out_live     (live),
        .out_button   (button),
        .out_ringer   (ringer),
        .out_peak     (peak)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        ptka_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .item     (item),
            .wr       (wr),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    assign m_tdata = {1'b0, peak, ringer, button, live, status};

endmodule

// ===== src/ptka_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the peer table block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ptka_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // held result under backpressure
    `CHK_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid)
    // one transaction in flight at a time
    `CHK_ASSERT(a_one_in_flight, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)
    // status code in range
    `CHK_IMPLY(a_status_range, clk, rst_n, m_tvalid, m_tdata[2:0] <= 3'd4)
    // counts never exceed live, live never exceeds peak
    `CHK_IMPLY(a_count_order, clk, rst_n, m_tvalid,
               (m_tdata[7:3] <= m_tdata[22:18]) && (m_tdata[12:8] <= m_tdata[7:3]) &&
               (m_tdata[17:13] <= m_tdata[7:3]))

endmodule

bind peer_table_keepalive_aging ptka_checker u_ptka_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
